// ----- design/fpn_pkg.sv -----
// Shared types and constants of the fractal gradient-noise block.
// No dependencies; the interfaces, the top module and the dv files use it by scoped name.
`default_nettype none

package fpn_pkg;

   // Payload and configuration widths
   localparam int COORD_W    = 32;
   localparam int NOISE_W    = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Permutation table geometry
   localparam int TABLE_SIZE = 256;
   localparam int PERM_W     = 8;

   // Shuffle generator
   localparam logic [31:0] LCG_MUL = 32'd1664525;
   localparam logic [31:0] LCG_ADD = 32'd1013904223;

   // Fixed-point constants (Q16; NOISE_MAX is 1.0 in Q2.14)
   localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
   localparam int          FADE_C15  = 983040;
   localparam int          FADE_C10  = 655360;
   localparam int          NOISE_MAX = 16384;

   // Input opcodes
   localparam logic OP_RESEED = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEED        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVES     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LACUNARITY  = 2'd3;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_SAMPLE   = 2'd0,
      STATUS_REBUILT  = 2'd1,
      STATUS_UNSEEDED = 2'd2
   } status_type;

endpackage

`default_nettype wire

// ----- design/fpn_req_if.sv -----
// Request channel of the noise block: valid/ready plus op and coordinates.
// Depends on fpn_pkg for the payload widths.
`default_nettype none

interface fpn_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic signed [fpn_pkg::COORD_W-1:0]   x_coord;
   logic signed [fpn_pkg::COORD_W-1:0]   z_coord;

   modport source (output valid, output op, output x_coord, output z_coord, input ready);
   modport sink   (input valid, input op, input x_coord, input z_coord, output ready);
endinterface

`default_nettype wire

// ----- design/fpn_rsp_if.sv -----
// Response channel of the noise block: valid/ready plus noise value and status.
// Depends on fpn_pkg for the payload widths.
`default_nettype none

interface fpn_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [fpn_pkg::NOISE_W-1:0]   noise_value;
   logic [fpn_pkg::STATUS_W-1:0]         status;

   modport source (output valid, output noise_value, output status, input ready);
   modport sink   (input valid, input noise_value, input status, output ready);
endinterface

`default_nettype wire

// ----- design/fpn_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fpn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/fpn_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Gives quotient and remainder; no package dependencies.
`default_nettype none

module fpn_div #(
   parameter int DVD_W = 40,
   parameter int DVS_W = 22
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] dq_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   trial;
   logic             fits;

   // Shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, dq_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   // Control: busy flag, bit counter, one-cycle done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: remainder and quotient shift register
   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         dq_ff  <= {dq_ff[DVD_W-2:0], fits};
      end
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- design/fractal_perlin_noise_2d.sv -----
// Fractal 2D gradient noise: request channel takes op, x_coord, z_coord (Q16.16);
// response channel returns one noise_value (Q2.14) and status per request.
// A reseed request (op 0) fills the 256-byte permutation RAM with the identity,
// then shuffles it from the top entry down: each of the 255 swaps runs the
// generator through the shared multiplier, takes the swap index from the
// remainder of the SUM_W-bit bit-serial divider and swaps through the single
// RAM read port. A sample request runs the octave step sequence on the shared
// multiplier once per octave, then normalizes in the bit-serial divider; SUM_W
// is 36 plus the octave counter width (40 at the default). A sample before any
// reseed answers with a zero noise value and the not-seeded status.
// One request is in work at a time; req ready is high whenever the sequencer is
// free, even while a finished result waits in the output register. A stalled
// receiver holds the result; a completed item then waits until the output frees.
// Reset clears the sequencer, the output valid and the seeded flag and loads the
// register defaults; the permutation RAM is not cleared and needs a reseed.
// Configuration writes on the csr port take effect at once, without handshake.
`default_nettype none

module fractal_perlin_noise_2d #(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   fpn_req_if.sink                            req_ch,
   fpn_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [fpn_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fpn_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int SUM_W  = 36 + OCT_W;
   localparam int TOT_W  = 17 + OCT_W;
   localparam int DVS_W  = TOT_W + 2;
   localparam int ADDR_W = $clog2(fpn_pkg::TABLE_SIZE);
   localparam int GRAD_W = 19;
   localparam int FADE_W = 22;
   localparam int LERP_W = 20;

   // Octave sequencer steps
   localparam logic [4:0] STP_MULX   = 5'd0;
   localparam logic [4:0] STP_MULZ   = 5'd1;
   localparam logic [4:0] STP_FADE1X = 5'd2;
   localparam logic [4:0] STP_FADE1Z = 5'd3;
   localparam logic [4:0] STP_FADE2X = 5'd4;
   localparam logic [4:0] STP_FADE2Z = 5'd5;
   localparam logic [4:0] STP_FADE3X = 5'd6;
   localparam logic [4:0] STP_FADE3Z = 5'd7;
   localparam logic [4:0] STP_FADE4X = 5'd8;
   localparam logic [4:0] STP_FADE4Z = 5'd9;
   localparam logic [4:0] STP_LERPA  = 5'd10;
   localparam logic [4:0] STP_LERPB  = 5'd11;
   localparam logic [4:0] STP_HOLDL1 = 5'd12;
   localparam logic [4:0] STP_LERPV  = 5'd13;
   localparam logic [4:0] STP_NOISE  = 5'd14;
   localparam logic [4:0] STP_WEIGHT = 5'd15;
   localparam logic [4:0] STP_ACCUM  = 5'd16;
   localparam logic [4:0] STP_AMP    = 5'd17;
   localparam logic [4:0] STP_FREQ   = 5'd18;

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_FILL = 13'b0000000000010,
      ST_LCG  = 13'b0000000000100,
      ST_SEED = 13'b0000000001000,
      ST_MODW = 13'b0000000010000,
      ST_RDI  = 13'b0000000100000,
      ST_RDJ  = 13'b0000001000000,
      ST_WRI  = 13'b0000010000000,
      ST_WRJ  = 13'b0000100000000,
      ST_OCT  = 13'b0001000000000,
      ST_DIVS = 13'b0010000000000,
      ST_DIVW = 13'b0100000000000,
      ST_DONE = 13'b1000000000000
   } state_type;

   // Gradient select: hash bit1 swaps the axes, bit0 and bit1 negate
   function automatic logic signed [GRAD_W-1:0] grad_dot(
      input logic [1:0]         h,
      input logic signed [17:0] dx,
      input logic signed [17:0] dz
   );
      logic signed [GRAD_W-1:0] u;
      logic signed [GRAD_W-1:0] v;
      u = h[1] ? GRAD_W'(dz) : GRAD_W'(dx);
      v = h[1] ? GRAD_W'(dx) : GRAD_W'(dz);
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + v;
   endfunction

   // Control state
   state_type            state_ff;
   logic [4:0]           step_ff;
   logic                 table_ready_ff;
   logic                 rsp_valid_ff;

   // Configuration registers
   logic [31:0]          seed_ff;
   logic [3:0]           octc_ff;
   logic [15:0]          pers_ff;
   logic [15:0]          lac_ff;

   // Sample datapath registers
   logic signed [31:0]   x_ff;
   logic signed [31:0]   z_ff;
   logic [31:0]          freq_ff;
   logic [16:0]          amp_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [TOT_W-1:0]     total_ff;
   logic [OCT_W-1:0]     oct_ff;
   logic [OCT_W-1:0]     noct_ff;
   logic [15:0]          fx_ff;
   logic [15:0]          fz_ff;
   logic [7:0]           cx_ff;
   logic [7:0]           cz_ff;
   logic [7:0]           a_ff;
   logic [7:0]           b_ff;
   logic [1:0]           h00_ff;
   logic [1:0]           h10_ff;
   logic [1:0]           h01_ff;
   logic [1:0]           h11_ff;
   logic signed [FADE_W-1:0] fxa_ff;
   logic signed [FADE_W-1:0] fza_ff;
   logic signed [17:0]   u_ff;
   logic signed [17:0]   v_ff;
   logic signed [LERP_W-1:0] l0_ff;
   logic signed [LERP_W-1:0] l1_ff;
   logic signed [65:0]   prod_ff;

   // Shuffle registers
   logic [31:0]          s_ff;
   logic [7:0]           i_ff;
   logic [7:0]           j_ff;
   logic [7:0]           t_ff;

   // Result registers
   logic signed [15:0]   res_noise_ff;
   fpn_pkg::status_type  res_status_ff;
   logic signed [15:0]   noise_out_ff;
   fpn_pkg::status_type  status_out_ff;

   // Combinational signals
   logic                 req_acc;
   logic [OCT_W-1:0]     noct;
   logic [4:0]           octc_w;
   logic                 oct_last;
   logic signed [32:0]   mul_a;
   logic signed [32:0]   mul_b;
   logic [18:0]          fx6;
   logic [18:0]          fz6;
   logic signed [17:0]   dx0;
   logic signed [17:0]   dx1;
   logic signed [17:0]   dz0;
   logic signed [17:0]   dz1;
   logic signed [GRAD_W-1:0] g00;
   logic signed [GRAD_W-1:0] g10;
   logic signed [GRAD_W-1:0] g01;
   logic signed [GRAD_W-1:0] g11;
   logic [31:0]          s_next;
   logic [SUM_W-1:0]     sum_mag;
   logic [15:0]          q_sat;
   logic                 div_start;
   logic [SUM_W-1:0]     div_dvd;
   logic [DVS_W-1:0]     div_dvs;
   logic                 div_done;
   logic [SUM_W-1:0]     div_quo;
   logic [DVS_W-1:0]     div_rem;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [7:0]           ram_wdata;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [7:0]           ram_rd;

   // Handshake
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.noise_value = noise_out_ff;
   assign rsp_ch.status      = status_out_ff;

   // Clamp the octave count to one through MAX_OCTAVES
   assign octc_w = {1'b0, octc_ff};
   always_comb begin
      if (octc_ff == 4'd0) begin
         noct = OCT_W'(1);
      end else if (octc_w > 5'(MAX_OCTAVES)) begin
         noct = OCT_W'(MAX_OCTAVES);
      end else begin
         noct = OCT_W'(octc_ff);
      end
   end

   assign oct_last = ({1'b0, oct_ff} + 1'b1) == {1'b0, noct_ff};

   // Corner offsets and gradients
   assign dx0 = $signed({2'b00, fx_ff});
   assign dz0 = $signed({2'b00, fz_ff});
   assign dx1 = dx0 - 18'sd65536;
   assign dz1 = dz0 - 18'sd65536;
   assign g00 = grad_dot(h00_ff, dx0, dz0);
   assign g10 = grad_dot(h10_ff, dx1, dz0);
   assign g01 = grad_dot(h01_ff, dx0, dz1);
   assign g11 = grad_dot(h11_ff, dx1, dz1);

   assign fx6 = {1'b0, fx_ff, 2'b00} + {2'b00, fx_ff, 1'b0};
   assign fz6 = {1'b0, fz_ff, 2'b00} + {2'b00, fz_ff, 1'b0};

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_LCG: begin
            mul_a = $signed({1'b0, s_ff});
            mul_b = $signed({1'b0, fpn_pkg::LCG_MUL});
         end
         ST_OCT: begin
            case (step_ff)
               STP_MULX: begin
                  mul_a = 33'(x_ff);
                  mul_b = $signed({1'b0, freq_ff});
               end
               STP_MULZ: begin
                  mul_a = 33'(z_ff);
                  mul_b = $signed({1'b0, freq_ff});
               end
               STP_FADE1X: begin
                  mul_a = $signed({17'd0, fx_ff});
                  mul_b = $signed({14'd0, fx6}) - 33'(fpn_pkg::FADE_C15);
               end
               STP_FADE1Z: begin
                  mul_a = $signed({17'd0, fz_ff});
                  mul_b = $signed({14'd0, fz6}) - 33'(fpn_pkg::FADE_C15);
               end
               STP_FADE2X, STP_FADE3X, STP_FADE4X: begin
                  mul_a = $signed({17'd0, fx_ff});
                  mul_b = 33'(fxa_ff);
               end
               STP_FADE2Z, STP_FADE3Z, STP_FADE4Z: begin
                  mul_a = $signed({17'd0, fz_ff});
                  mul_b = 33'(fza_ff);
               end
               STP_LERPA: begin
                  mul_a = 33'(g10) - 33'(g00);
                  mul_b = 33'(u_ff);
               end
               STP_LERPB: begin
                  mul_a = 33'(g11) - 33'(g01);
                  mul_b = 33'(u_ff);
               end
               STP_LERPV: begin
                  mul_a = 33'(l1_ff) - 33'(l0_ff);
                  mul_b = 33'(v_ff);
               end
               STP_WEIGHT: begin
                  mul_a = 33'(l0_ff);
                  mul_b = $signed({16'd0, amp_ff});
               end
               STP_ACCUM: begin
                  mul_a = $signed({16'd0, amp_ff});
                  mul_b = $signed({17'd0, pers_ff});
               end
               STP_AMP: begin
                  mul_a = $signed({1'b0, freq_ff});
                  mul_b = $signed({17'd0, lac_ff});
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Permutation RAM ports
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = i_ff;
      ram_wdata = i_ff;
      case (state_ff)
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = i_ff;
         end
         ST_WRI: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = ram_rd;
         end
         ST_WRJ: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = t_ff;
         end
         default: ram_we = 1'b0;
      endcase
   end

   always_comb begin
      ram_raddr = '0;
      case (state_ff)
         ST_RDI: ram_raddr = i_ff;
         ST_RDJ: ram_raddr = j_ff;
         ST_OCT: begin
            case (step_ff)
               STP_FADE1X: ram_raddr = cx_ff;
               STP_FADE1Z: ram_raddr = cx_ff + 8'd1;
               STP_FADE2X: ram_raddr = a_ff;
               STP_FADE2Z: ram_raddr = b_ff;
               STP_FADE3X: ram_raddr = a_ff + 8'd1;
               STP_FADE3Z: ram_raddr = b_ff + 8'd1;
               default:    ram_raddr = '0;
            endcase
         end
         default: ram_raddr = '0;
      endcase
   end

   fpn_ram #(
      .WIDTH (fpn_pkg::PERM_W),
      .DEPTH (fpn_pkg::TABLE_SIZE)
   ) u_perm_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd)
   );

   // Divider shared by the swap index and the final normalization
   assign s_next    = prod_ff[31:0] + fpn_pkg::LCG_ADD;
   assign sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_start = (state_ff == ST_SEED) || (state_ff == ST_DIVS);
   assign div_dvd   = (state_ff == ST_SEED) ? SUM_W'(s_next) : sum_mag;
   assign div_dvs   = (state_ff == ST_SEED) ? DVS_W'({1'b0, i_ff} + 9'd1)
                                            : DVS_W'({total_ff, 2'b00});

   fpn_div #(
      .DVD_W (SUM_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Saturate the quotient magnitude
   assign q_sat = (div_quo > SUM_W'(fpn_pkg::NOISE_MAX)) ? 16'(fpn_pkg::NOISE_MAX)
                                                        : div_quo[15:0];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd0;
         octc_ff <= 4'd4;
         pers_ff <= 16'd32768;
         lac_ff  <= 16'd8192;
      end else if (csr_we) begin
         case (csr_index)
            fpn_pkg::CSR_SEED:        seed_ff <= csr_wdata;
            fpn_pkg::CSR_OCTAVES:     octc_ff <= csr_wdata[3:0];
            fpn_pkg::CSR_PERSISTENCE: pers_ff <= csr_wdata[15:0];
            fpn_pkg::CSR_LACUNARITY:  lac_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Sequencer and datapath captures
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= STP_MULX;
         table_ready_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // Load a finished item, or drop the result once the transfer completes
         if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  x_ff <= req_ch.x_coord;
                  z_ff <= req_ch.z_coord;
                  if (req_ch.op == fpn_pkg::OP_RESEED) begin
                     i_ff     <= '0;
                     state_ff <= ST_FILL;
                  end else if (!table_ready_ff) begin
                     res_noise_ff  <= '0;
                     res_status_ff <= fpn_pkg::STATUS_UNSEEDED;
                     state_ff      <= ST_DONE;
                  end else begin
                     noct_ff  <= noct;
                     oct_ff   <= '0;
                     step_ff  <= STP_MULX;
                     freq_ff  <= fpn_pkg::ONE_Q16;
                     amp_ff   <= 17'h1_0000;
                     sum_ff   <= '0;
                     total_ff <= '0;
                     state_ff <= ST_OCT;
                  end
               end
            end
            ST_FILL: begin
               if (i_ff == 8'hFF) begin
                  s_ff     <= seed_ff;
                  state_ff <= ST_LCG;
               end else begin
                  i_ff <= i_ff + 8'd1;
               end
            end
            ST_LCG: state_ff <= ST_SEED;
            ST_SEED: begin
               s_ff     <= s_next;
               state_ff <= ST_MODW;
            end
            ST_MODW: begin
               if (div_done) begin
                  j_ff     <= div_rem[7:0];
                  state_ff <= ST_RDI;
               end
            end
            ST_RDI: state_ff <= ST_RDJ;
            ST_RDJ: begin
               t_ff     <= ram_rd;
               state_ff <= ST_WRI;
            end
            ST_WRI: state_ff <= ST_WRJ;
            ST_WRJ: begin
               if (i_ff == 8'd1) begin
                  table_ready_ff <= 1'b1;
                  res_noise_ff   <= '0;
                  res_status_ff  <= fpn_pkg::STATUS_REBUILT;
                  state_ff       <= ST_DONE;
               end else begin
                  i_ff     <= i_ff - 8'd1;
                  state_ff <= ST_LCG;
               end
            end
            ST_OCT: begin
               step_ff <= (step_ff == STP_FREQ) ? STP_MULX : step_ff + 5'd1;
               case (step_ff)
                  STP_MULZ: begin
                     cx_ff <= prod_ff[39:32];
                     fx_ff <= prod_ff[31:16];
                  end
                  STP_FADE1X: begin
                     cz_ff <= prod_ff[39:32];
                     fz_ff <= prod_ff[31:16];
                  end
                  STP_FADE1Z: begin
                     fxa_ff <= prod_ff[16 +: FADE_W] + FADE_W'(fpn_pkg::FADE_C10);
                     a_ff   <= ram_rd + cz_ff;
                  end
                  STP_FADE2X: begin
                     fza_ff <= prod_ff[16 +: FADE_W] + FADE_W'(fpn_pkg::FADE_C10);
                     b_ff   <= ram_rd + cz_ff;
                  end
                  STP_FADE2Z: begin
                     fxa_ff <= prod_ff[16 +: FADE_W];
                     h00_ff <= ram_rd[1:0];
                  end
                  STP_FADE3X: begin
                     fza_ff <= prod_ff[16 +: FADE_W];
                     h10_ff <= ram_rd[1:0];
                  end
                  STP_FADE3Z: begin
                     fxa_ff <= prod_ff[16 +: FADE_W];
                     h01_ff <= ram_rd[1:0];
                  end
                  STP_FADE4X: begin
                     fza_ff <= prod_ff[16 +: FADE_W];
                     h11_ff <= ram_rd[1:0];
                  end
                  STP_FADE4Z: u_ff  <= prod_ff[33:16];
                  STP_LERPA:  v_ff  <= prod_ff[33:16];
                  STP_LERPB:  l0_ff <= LERP_W'(g00) + prod_ff[16 +: LERP_W];
                  STP_HOLDL1: l1_ff <= LERP_W'(g01) + prod_ff[16 +: LERP_W];
                  STP_NOISE:  l0_ff <= l0_ff + prod_ff[16 +: LERP_W];
                  STP_ACCUM: begin
                     sum_ff   <= sum_ff + prod_ff[SUM_W-1:0];
                     total_ff <= total_ff + TOT_W'(amp_ff);
                  end
                  STP_AMP: amp_ff <= prod_ff[32:16];
                  STP_FREQ: begin
                     freq_ff <= (prod_ff[47:44] != 4'd0) ? 32'hFFFF_FFFF : prod_ff[43:12];
                     oct_ff  <= oct_ff + 1'b1;
                     if (oct_last) begin
                        state_ff <= ST_DIVS;
                     end
                  end
                  default: ;
               endcase
            end
            ST_DIVS: state_ff <= ST_DIVW;
            ST_DIVW: begin
               if (div_done) begin
                  res_noise_ff  <= sum_ff[SUM_W-1] ? -$signed(q_sat) : $signed(q_sat);
                  res_status_ff <= fpn_pkg::STATUS_SAMPLE;
                  state_ff      <= ST_DONE;
               end
            end
            ST_DONE: begin
               // Hold the item until the output register is free
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  noise_out_ff  <= res_noise_ff;
                  status_out_ff <= res_status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_unseeded: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_ch.op == fpn_pkg::OP_SAMPLE) && !table_ready_ff |=>
         (state_ff == ST_DONE) && (res_status_ff == fpn_pkg::STATUS_UNSEEDED))
      else $error("sample before reseed did not answer not-seeded");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ($signed(rsp_ch.noise_value) <= 16'sd16384) &&
                       ($signed(rsp_ch.noise_value) >= -16'sd16384))
      else $error("noise value outside saturation range");

   a_zero_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status != fpn_pkg::STATUS_SAMPLE) |->
         (rsp_ch.noise_value == 16'd0))
      else $error("non-sample result with nonzero noise");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MODW) || (state_ff == ST_DIVW))
      else $error("divider finished with no waiting step");
`endif

endmodule

`default_nettype wire

// ----- dv/fpn_noise_checker.sv -----
// Checker for the fractal gradient-noise block: watches both channels and the csr port,
// keeps its own noise predictor and compares every response transfer against it.
// Depends on fpn_pkg and the fpn_req_if / fpn_rsp_if interfaces.
`timescale 1ns / 1ps

module fpn_noise_checker (
   input  logic                              clock,
   input  logic                              reset,
   fpn_req_if                                req,
   fpn_rsp_if                                rsp,
   input  logic                              csr_we,
   input  logic [fpn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fpn_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                fail_count,
   output int                                pending
);
   import fpn_pkg::*;

   localparam int OCTAVE_LIMIT = 8;

   typedef struct packed {
      logic signed [NOISE_W-1:0] noise;
      status_type                status;
   } noise_result_t;

   noise_result_t        noise_queue[$];
   logic [PERM_W-1:0]    perm[TABLE_SIZE];
   logic                 seeded;
   logic [31:0]          seed_reg;
   logic [3:0]           octave_reg;
   logic [15:0]          persist_reg;
   logic [15:0]          lacun_reg;

   task automatic report(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Quintic fade by Horner, every product floored
   function automatic longint fade(longint t);
      longint b;
      b = ((t * (6 * t - FADE_C15)) >>> 16) + FADE_C10;
      b = (t * b) >>> 16;
      b = (t * b) >>> 16;
      return (t * b) >>> 16;
   endfunction

   function automatic longint lerp(longint a, longint b, longint t);
      return a + (((b - a) * t) >>> 16);
   endfunction

   function automatic longint grad_dot(logic [7:0] h, longint dx, longint dz);
      longint u, v;
      u = h[1] ? dz : dx;
      v = h[1] ? dx : dz;
      if (h[0]) u = -u;
      if (h[1]) v = -v;
      return u + v;
   endfunction

   // Table rebuild: identity, then top-down shuffle driven by the LCG
   task automatic rebuild_table();
      logic [31:0] s;
      logic [31:0] j;
      logic [7:0]  t;
      s = seed_reg;
      for (int i = 0; i < TABLE_SIZE; i++) perm[i] = i[7:0];
      for (int i = TABLE_SIZE - 1; i > 0; i--) begin
         s = s * LCG_MUL + LCG_ADD;
         j = s % (i + 1);
         t = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      seeded = 1'b1;
   endtask

   function automatic logic signed [15:0] fbm_noise(logic signed [31:0] x, logic signed [31:0] z);
      longint unsigned px, pz, nf;
      longint          fx, fz, u, v, l0, l1, n, sum, total, amp, q;
      logic [31:0]     freq;
      logic [7:0]      cx, cz, a, b;
      int              octs;
      octs = (octave_reg == 0) ? 1 : (octave_reg > OCTAVE_LIMIT ? OCTAVE_LIMIT : octave_reg);
      freq = ONE_Q16;
      amp = 65536;
      sum = 0;
      total = 0;
      for (int k = 0; k < octs; k++) begin
         px = longint'(x) * longint'({32'd0, freq});
         pz = longint'(z) * longint'({32'd0, freq});
         fx = px[31:16];
         fz = pz[31:16];
         cx = px[39:32];
         cz = pz[39:32];
         u = fade(fx);
         v = fade(fz);
         a = perm[cx] + cz;
         b = perm[8'(cx + 1)] + cz;
         l0 = lerp(grad_dot(perm[a], fx, fz), grad_dot(perm[b], fx - 65536, fz), u);
         l1 = lerp(grad_dot(perm[8'(a + 1)], fx, fz - 65536),
                   grad_dot(perm[8'(b + 1)], fx - 65536, fz - 65536), u);
         n = lerp(l0, l1, v);
         sum += n * amp;
         total += amp;
         amp = (amp * persist_reg) >>> 16;
         nf = (longint'({32'd0, freq}) * lacun_reg) >> 12;
         freq = (nf > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nf[31:0];
      end
      q = sum / (total * 4);
      if (q > NOISE_MAX) q = NOISE_MAX;
      if (q < -NOISE_MAX) q = -NOISE_MAX;
      return q[15:0];
   endfunction

   // Track csr writes, predict on request transfers, compare on response transfers
   always @(posedge clock) begin
      noise_result_t want;
      if (reset) begin
         noise_queue.delete();
         seeded = 1'b0;
         seed_reg = 32'd0;
         octave_reg = 4'd4;
         persist_reg = 16'd32768;
         lacun_reg = 16'd8192;
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SEED:        seed_reg = csr_wdata;
               CSR_OCTAVES:     octave_reg = csr_wdata[3:0];
               CSR_PERSISTENCE: persist_reg = csr_wdata[15:0];
               CSR_LACUNARITY:  lacun_reg = csr_wdata[15:0];
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (noise_queue.size() == 0) begin
               $display("%0t: response transfer with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = noise_queue.pop_front();
               if (rsp.noise_value !== want.noise)
                  report("noise_value", rsp.noise_value, want.noise);
               if (rsp.status !== want.status)
                  report("status", rsp.status, want.status);
            end
         end
         if (req.valid && req.ready) begin
            if (req.op == OP_RESEED) begin
               rebuild_table();
               want = '{noise: '0, status: STATUS_REBUILT};
            end else if (!seeded) begin
               want = '{noise: '0, status: STATUS_UNSEEDED};
            end else begin
               want = '{noise: fbm_noise(req.x_coord, req.z_coord), status: STATUS_SAMPLE};
            end
            noise_queue.push_back(want);
         end
      end
      pending = noise_queue.size();
   end
endmodule

// ----- dv/tb.sv -----
// Testbench top for fractal_perlin_noise_2d: clock, reset, request and csr stimulus,
// randomly stalling response sink and the final verdict. Depends on fpn_pkg, the
// channel interfaces, the block itself and fpn_noise_checker.
`timescale 1ns / 1ps

module tb;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [fpn_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [fpn_pkg::CSR_DATA_W-1:0]  csr_wdata;
   int                              fail_count;
   int                              pending;

   fpn_req_if req_ch();
   fpn_rsp_if rsp_ch();

   fractal_perlin_noise_2d i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fpn_noise_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(logic op, logic [31:0] x, logic [31:0] z);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.x_coord <= x;
      req_ch.z_coord <= z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off until every expected response has arrived
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [fpn_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [31:0] seed, logic [3:0] octs, logic [15:0] pers,
                            logic [15:0] lac);
      drain();
      write_csr(fpn_pkg::CSR_SEED, seed);
      write_csr(fpn_pkg::CSR_OCTAVES, {28'd0, octs});
      write_csr(fpn_pkg::CSR_PERSISTENCE, {16'd0, pers});
      write_csr(fpn_pkg::CSR_LACUNARITY, {16'd0, lac});
   endtask

   // Mixed coordinates: full range or within 16 cells of the origin
   function automatic logic [31:0] pick_coord();
      if ($urandom_range(0, 1)) return $urandom();
      return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
   endfunction

   task automatic random_items(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 3) send(fpn_pkg::OP_RESEED, $urandom(), $urandom());
         else send(fpn_pkg::OP_SAMPLE, pick_coord(), pick_coord());
      end
   endtask

   // Response sink: stall stretches of random length, with long runs of ready
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      forever begin
         n = $urandom_range(0, 99);
         if (n < 60) n = 0;
         else if (n < 92) n = $urandom_range(1, 3);
         else n = $urandom_range(10, 50);
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 8)) @(negedge clock);
      end
   end

   // Run limit
   initial begin
      #40ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.op = fpn_pkg::OP_SAMPLE;
      req_ch.x_coord = '0;
      req_ch.z_coord = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Samples before any reseed answer not seeded
      send(fpn_pkg::OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
      send(fpn_pkg::OP_SAMPLE, 32'h0000_0000, 32'h0000_0000);
      // Default settings, seed zero
      send(fpn_pkg::OP_RESEED, 32'd0, 32'd0);
      send(fpn_pkg::OP_SAMPLE, 32'h0000_0000, 32'h0000_0000);
      send(fpn_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000);
      send(fpn_pkg::OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
      send(fpn_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0001);
      send(fpn_pkg::OP_SAMPLE, 32'h0000_FFFF, 32'hFFFF_0000);
      send(fpn_pkg::OP_SAMPLE, 32'h0000_8000, 32'h0000_8000);
      send(fpn_pkg::OP_SAMPLE, 32'h00FF_C000, 32'hFF00_4000);
      send(fpn_pkg::OP_SAMPLE, 32'hAAAA_AAAA, 32'h5555_5555);
      send(fpn_pkg::OP_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA);
      // Extremes: all-ones seed, zero octaves, zero persistence and lacunarity
      configure(32'hFFFF_FFFF, 4'd0, 16'd0, 16'd0);
      send(fpn_pkg::OP_RESEED, 32'd0, 32'd0);
      send(fpn_pkg::OP_SAMPLE, 32'h0001_8000, 32'hFFFE_4000);
      send(fpn_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      random_items(60);
      // Octave count above the limit, full persistence and lacunarity
      configure(32'd12345, 4'd15, 16'hFFFF, 16'hFFFF);
      send(fpn_pkg::OP_RESEED, 32'd0, 32'd0);
      send(fpn_pkg::OP_SAMPLE, 32'h8000_0000, 32'h8000_0000);
      send(fpn_pkg::OP_SAMPLE, 32'h0000_0001, 32'hFFFF_FFFF);
      random_items(110);
      // Typical terrain settings
      configure($urandom(), 4'd8, 16'd32768, 16'd8192);
      send(fpn_pkg::OP_RESEED, 32'd0, 32'd0);
      random_items(120);
      // Single octave
      configure($urandom(), 4'd1, 16'($urandom()), 16'($urandom()));
      send(fpn_pkg::OP_RESEED, 32'd0, 32'd0);
      random_items(110);
      // Random settings
      configure($urandom(), 4'($urandom_range(1, 8)), 16'($urandom()),
                16'($urandom_range(4096, 12288)));
      send(fpn_pkg::OP_RESEED, 32'd0, 32'd0);
      random_items(110);

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
